### design/texture_slot_cache_defines.svh
// assertion helpers used by texture_slot_cache
`ifndef TEXTURE_SLOT_CACHE_DEFINES_SVH
`define TEXTURE_SLOT_CACHE_DEFINES_SVH

// plain property, checked on every rising clock edge outside reset
`define TSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### design/tsc_pkg.sv
package tsc_pkg;

   localparam int ID_PORT_W   = 16;
   localparam int SRC_SLOT_W  = 4;
   localparam int RSP_SLOT_W  = 4;
   localparam int EVICT_CNT_W = 32;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

### design/texture_slot_cache.sv
// Fully associative image-id to slot table with first-in first-out replacement. A lookup
// walks the filled entries through the single read port of the entry memory, one entry per
// cycle, and stops at the first match; a zero image id skips the walk and gets no slot.
// The next request is taken as soon as the lookup has finished, while the response may
// still be waiting. On a miss the next empty slot is filled, or once the table is full the
// round-robin pointer picks the victim; evictions are counted and flush_first is raised
// when the victim is the bound drawing source. Image ids are compared on their low ID_BITS.
module texture_slot_cache #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ID_BITS       = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tsc_pkg::ID_PORT_W-1:0]   req_image_id,
   input  logic [tsc_pkg::SRC_SLOT_W-1:0]  req_source_slot,
   input  logic                            req_source_valid,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_valid_res,
   output logic [tsc_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic                            rsp_hit,
   output logic                            rsp_evicted,
   output logic                            rsp_flush_first,
   output logic [tsc_pkg::EVICT_CNT_W-1:0] rsp_eviction_total
);
   import tsc_pkg::*;

   localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = SLOT_W + 1;
   localparam int KEY_W  = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
   localparam int CMP_W  = (SLOT_W > SRC_SLOT_W) ? SLOT_W : SRC_SLOT_W;
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_ENTRIES);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

   state_type               state_ff, state_in;
   logic [KEY_W-1:0]        key_ff;
   logic [SRC_SLOT_W-1:0]   src_ff;
   logic                    srcv_ff;
   logic                    zero_ff;
   logic [CNT_W-1:0]        issue_idx_ff, issue_idx_in;
   logic [SLOT_W-1:0]       chk_idx_ff;
   logic                    chk_vld_ff, chk_vld_in;
   logic [KEY_W-1:0]        rdata_ff;
   logic [KEY_W-1:0]        entry_image_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [SLOT_W-1:0]       ptr_ff, ptr_in;
   logic [EVICT_CNT_W-1:0]  ev_cnt_ff, ev_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_valid_res_ff;
   logic [RSP_SLOT_W-1:0]   rsp_slot_ff;
   logic                    rsp_hit_ff;
   logic                    rsp_evicted_ff;
   logic                    rsp_flush_first_ff;
   logic [EVICT_CNT_W-1:0]  rsp_eviction_total_ff;

   logic                    accept;
   logic                    issuing;
   logic                    match;
   logic                    out_free;
   logic                    finish;
   logic                    advance;
   logic                    miss;
   logic                    full;
   logic                    evict;
   logic                    flush;
   logic [SLOT_W-1:0]       target;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign issuing  = (issue_idx_ff < fill_ff);
   assign match    = chk_vld_ff && (rdata_ff == key_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == ST_SCAN) && out_free &&
                     (zero_ff || match || (!issuing && !chk_vld_ff));
   assign advance  = (state_ff == ST_SCAN) && !zero_ff && !match && (issuing || chk_vld_ff);
   assign miss     = !zero_ff && !match;
   assign full     = (fill_ff == FULL_CNT);
   assign target   = match ? chk_idx_ff : (full ? ptr_ff : fill_ff[SLOT_W-1:0]);
   assign evict    = miss && full;
   assign flush    = evict && srcv_ff && (CMP_W'(src_ff) == CMP_W'(target));

   always_comb begin
      state_in     = state_ff;
      issue_idx_in = issue_idx_ff;
      chk_vld_in   = chk_vld_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      ev_cnt_in    = ev_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_SCAN;
               issue_idx_in = '0;
               chk_vld_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               chk_vld_in   = issuing;
               issue_idx_in = issue_idx_ff + CNT_W'(issuing);
            end
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (miss && !full) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               if (evict) begin
                  ptr_in    = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + SLOT_W'(1);
                  ev_cnt_in = ev_cnt_ff + EVICT_CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_idx_ff <= '0;
         chk_vld_ff   <= 1'b0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         ev_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_idx_ff <= issue_idx_in;
         chk_vld_ff   <= chk_vld_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         ev_cnt_ff    <= ev_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and compare pipeline
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= req_image_id[KEY_W-1:0];
         zero_ff <= (req_image_id[KEY_W-1:0] == '0);
         src_ff  <= req_source_slot;
         srcv_ff <= req_source_valid;
      end
      if (advance) begin
         chk_idx_ff <= issue_idx_ff[SLOT_W-1:0];
      end
   end

   // entry memory: entries at or above the fill count are never compared
   always_ff @(posedge clock) begin
      if (finish && miss) begin
         entry_image_ff[target] <= key_ff;
      end
      if (advance) begin
         rdata_ff <= entry_image_ff[issue_idx_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_valid_res_ff      <= !zero_ff;
         rsp_slot_ff           <= zero_ff ? '0 : RSP_SLOT_W'(target);
         rsp_hit_ff            <= match;
         rsp_evicted_ff        <= evict;
         rsp_flush_first_ff    <= flush;
         rsp_eviction_total_ff <= ev_cnt_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_res      = rsp_valid_res_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_flush_first    = rsp_flush_first_ff;
   assign rsp_eviction_total = rsp_eviction_total_ff;

`include "texture_slot_cache_defines.svh"

   `TSC_ASSERT(a_fill_bound, clock, reset, fill_ff <= FULL_CNT, "fill count beyond table size")
   `TSC_ASSERT_IMP(a_ptr_only_when_full, clock, reset, ptr_ff != '0, full, "pointer moved before table full")
   `TSC_ASSERT_IMP(a_flush_needs_evict, clock, reset, rsp_valid_ff && rsp_flush_first_ff, rsp_evicted_ff, "flush without eviction")
   `TSC_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid_ff && rsp_hit_ff, !rsp_evicted_ff && rsp_valid_res_ff, "hit response marks eviction")
   `TSC_ASSERT_IMP(a_write_in_range, clock, reset, finish && miss && !full, fill_ff < FULL_CNT, "fill slot out of range")

endmodule
